[hdl/lbce_pkg.sv]
`timescale 1ns / 1ps
package lbce_pkg;

  localparam int WORD_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int DU_W    = WORD_W - 1;
  localparam int Y_W     = 2 * WORD_W;
  localparam int SQ_W    = 4 * WORD_W;
  localparam int ROOT_W  = 2 * WORD_W;
  localparam int NUM1_W  = 3 * WORD_W;
  localparam int DEN1_W  = ROOT_W + 1;
  localparam int PP_W    = 2 * WORD_W;
  localparam int PQ_W    = PP_W + 1;
  localparam int DEN2_W  = PQ_W + FRAC_W;
  localparam int NUM2_W  = 4 * WORD_W;

  // 4.0 in the Q.(4F) square, 2.0 in the Q.(2F) root
  localparam logic [SQ_W-1:0]   SQ_BIAS  = SQ_W'(1) << (4 * FRAC_W + 2);
  localparam logic [DEN1_W-1:0] DEN_BIAS = DEN1_W'(2) << (2 * FRAC_W);

  localparam logic [WORD_W-1:0] LOWER_RST = WORD_W'(32768);
  localparam logic [WORD_W-1:0] UPPER_RST = WORD_W'(819200);
  localparam logic [DU_W-1:0]   DU_MAX    = {DU_W{1'b1}};

  localparam logic CFG_LOWER = 1'b0;
  localparam logic CFG_UPPER = 1'b1;

  typedef struct packed {
    logic [NUM1_W-1:0] num;
    logic              neg;
    logic              last;
  } sqrt_sb_t;

  typedef struct packed {
    logic neg;
    logic last;
  } div1_sb_t;

  typedef struct packed {
    logic [WORD_W-1:0] u;
    logic              sat_u;
    logic              pz;
    logic              ovf;
    logic              last;
  } div2_sb_t;

endpackage

[hdl/log_barrier_closure_eval_core.sv]
`timescale 1ns / 1ps
// channel  handshake               ports
// in       start & !busy           in_lambda, in_last_element
// out      out_valid (one cycle)   out_u_value, out_du_value, out_last_out, out_saturated
// cfg      cfg_we                  cfg_index, cfg_wdata
//
// One word accepted per cycle while busy is low.
// Latency is set by the 64-stage square root and the 32- and 31-stage dividers.
// rst_n is synchronous; busy is high only while reset is held.
// Results cannot be held off, so the pipeline advances every cycle.
module log_barrier_closure_eval_core
  import lbce_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [WORD_W-1:0] in_lambda,
  input  logic                     in_last_element,
  output logic                     out_valid,
  output logic signed [WORD_W-1:0] out_u_value,
  output logic [DU_W-1:0]          out_du_value,
  output logic                     out_last_out,
  output logic                     out_saturated,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [WORD_W-1:0]        cfg_wdata
);

  localparam int LATENCY = 12 + ROOT_W + WORD_W + DU_W;

  logic [WORD_W-1:0] lower_r, upper_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= LOWER_RST;
      upper_r <= UPPER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOWER: lower_r <= cfg_wdata;
        CFG_UPPER: upper_r <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  assign busy = !rst_n;

  logic acc;
  assign acc = start && !busy;

  // ---------------- front: |b-a|, |lambda|, products ----------------
  logic              s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic [WORD_W-1:0] s1_d_r, s1_lm_r, s2_d_r;
  logic              s1_neg_r, s1_last_r, s2_neg_r, s2_last_r, s3_neg_r, s3_last_r;
  logic              s4_neg_r, s4_last_r;
  logic [Y_W-1:0]    s2_y_r;
  logic [Y_W-1:0]    s3_ll_r, s3_lh_r, s3_hh_r, s3_dl_r, s3_dh_r;
  logic [SQ_W-1:0]   s4_sq_r;
  logic [NUM1_W-1:0] s4_num_r;

  logic signed [WORD_W:0] diff_nxt;
  logic [WORD_W:0]        dmag_nxt;
  logic [WORD_W-1:0]      lm_nxt;
  logic [SQ_W-1:0]        sq_nxt;
  logic [NUM1_W-1:0]      num_nxt;

  always_comb begin
    diff_nxt = $signed({upper_r[WORD_W-1], upper_r}) - $signed({lower_r[WORD_W-1], lower_r});
    dmag_nxt = diff_nxt[WORD_W] ? (WORD_W+1)'(-diff_nxt) : diff_nxt;
    lm_nxt   = in_lambda[WORD_W-1] ? WORD_W'(-in_lambda) : in_lambda;
    sq_nxt   = (SQ_W'(s3_hh_r) << (2 * WORD_W)) + (SQ_W'(s3_lh_r) << (WORD_W + 1))
             + SQ_W'(s3_ll_r) + SQ_BIAS;
    num_nxt  = (NUM1_W'(s3_dh_r) << WORD_W) + NUM1_W'(s3_dl_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_d_r    <= dmag_nxt[WORD_W-1:0];
    s1_lm_r   <= lm_nxt;
    s1_neg_r  <= in_lambda[WORD_W-1];
    s1_last_r <= in_last_element;

    s2_y_r    <= Y_W'(s1_d_r) * Y_W'(s1_lm_r);
    s2_d_r    <= s1_d_r;
    s2_neg_r  <= s1_neg_r;
    s2_last_r <= s1_last_r;

    s3_ll_r   <= Y_W'(s2_y_r[WORD_W-1:0]) * Y_W'(s2_y_r[WORD_W-1:0]);
    s3_lh_r   <= Y_W'(s2_y_r[WORD_W-1:0]) * Y_W'(s2_y_r[Y_W-1:WORD_W]);
    s3_hh_r   <= Y_W'(s2_y_r[Y_W-1:WORD_W]) * Y_W'(s2_y_r[Y_W-1:WORD_W]);
    s3_dl_r   <= Y_W'(s2_d_r) * Y_W'(s2_y_r[WORD_W-1:0]);
    s3_dh_r   <= Y_W'(s2_d_r) * Y_W'(s2_y_r[Y_W-1:WORD_W]);
    s3_neg_r  <= s2_neg_r;
    s3_last_r <= s2_last_r;

    s4_sq_r   <= sq_nxt;
    s4_num_r  <= num_nxt;
    s4_neg_r  <= s3_neg_r;
    s4_last_r <= s3_last_r;
  end

  // ---------------- sqrt(y^2 + 4) ----------------
  sqrt_sb_t          sq_sb_in, sq_sb_out;
  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;

  assign sq_sb_in = '{num: s4_num_r, neg: s4_neg_r, last: s4_last_r};

  lbce_sqrt_pipe #(
    .ROOT_W (ROOT_W),
    .SB_W   ($bits(sqrt_sb_t))
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (s4_v_r),
    .in_n     (s4_sq_r),
    .in_sb    (sq_sb_in),
    .out_v    (sq_v),
    .out_root (sq_root),
    .out_sb   (sq_sb_out)
  );

  logic              s5_v_r;
  logic [DEN1_W-1:0] s5_den_r;
  logic [NUM1_W-1:0] s5_num_r;
  div1_sb_t          s5_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else begin
      s5_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    s5_den_r <= {1'b0, sq_root} + DEN_BIAS;
    s5_num_r <= sq_sb_out.num;
    s5_sb_r  <= '{neg: sq_sb_out.neg, last: sq_sb_out.last};
  end

  // ---------------- t = d*y / (s + 2) ----------------
  logic              d1_v;
  logic [WORD_W-1:0] d1_t;
  div1_sb_t          d1_sb;

  lbce_div_pipe #(
    .NUM_W (NUM1_W),
    .DEN_W (DEN1_W),
    .Q_W   (WORD_W),
    .SB_W  ($bits(div1_sb_t))
  ) u_div_t (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (s5_v_r),
    .in_num  (s5_num_r),
    .in_den  (s5_den_r),
    .in_sb   (s5_sb_r),
    .out_v   (d1_v),
    .out_quo (d1_t),
    .out_sb  (d1_sb)
  );

  // ---------------- u, p, q and the derivative terms ----------------
  logic              s6_v_r, s7_v_r, s8_v_r, s9_v_r, s10_v_r, s11_v_r;
  logic [WORD_W-1:0] s6_u_r;
  logic              s6_sat_r, s6_last_r;
  logic [WORD_W-1:0] s7_mp_r, s7_mq_r;
  div2_sb_t          s7_sb_r, s8_sb_r, s9_sb_r, s10_sb_r, s11_sb_r;
  logic [PP_W-1:0]   s8_pp_r, s8_qq_r;
  logic [PP_W-1:0]   s9_ll_r, s9_lh_r, s9_hl_r, s9_hh_r;
  logic [PQ_W-1:0]   s9_pq_r;
  logic [NUM2_W-1:0] s10_n_r, s11_n_r;
  logic [DEN2_W-1:0] s10_den_r, s11_den_r;

  logic signed [WORD_W+1:0] v_nxt, t_ext;
  logic signed [WORD_W:0]   u_wide;
  logic [WORD_W-1:0]        u_nxt;
  logic                     usat_nxt;
  logic signed [WORD_W:0]   p_nxt, q_nxt;
  logic [WORD_W:0]          pm_nxt, qm_nxt;
  logic [NUM2_W-1:0]        n2_nxt;
  logic                     ovf_nxt;

  always_comb begin
    t_ext  = $signed({2'b00, d1_t});
    v_nxt  = $signed({{2{lower_r[WORD_W-1]}}, lower_r}) + $signed({{2{upper_r[WORD_W-1]}}, upper_r})
           + (d1_sb.neg ? -t_ext : t_ext);
    u_wide = v_nxt[WORD_W+1:1];
    usat_nxt = u_wide[WORD_W] != u_wide[WORD_W-1];
    if (usat_nxt) begin
      u_nxt = u_wide[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end else begin
      u_nxt = u_wide[WORD_W-1:0];
    end

    p_nxt  = $signed({s6_u_r[WORD_W-1], s6_u_r}) - $signed({lower_r[WORD_W-1], lower_r});
    q_nxt  = $signed({upper_r[WORD_W-1], upper_r}) - $signed({s6_u_r[WORD_W-1], s6_u_r});
    pm_nxt = p_nxt[WORD_W] ? (WORD_W+1)'(-p_nxt) : p_nxt;
    qm_nxt = q_nxt[WORD_W] ? (WORD_W+1)'(-q_nxt) : q_nxt;

    n2_nxt = (NUM2_W'(s9_hh_r) << (2 * WORD_W)) + (NUM2_W'(s9_lh_r) << WORD_W)
           + (NUM2_W'(s9_hl_r) << WORD_W) + NUM2_W'(s9_ll_r);
    // quotient would not fit in the derivative field
    ovf_nxt = s10_n_r >= (NUM2_W'(s10_den_r) << DU_W);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r  <= 1'b0;
      s7_v_r  <= 1'b0;
      s8_v_r  <= 1'b0;
      s9_v_r  <= 1'b0;
      s10_v_r <= 1'b0;
      s11_v_r <= 1'b0;
    end else begin
      s6_v_r  <= d1_v;
      s7_v_r  <= s6_v_r;
      s8_v_r  <= s7_v_r;
      s9_v_r  <= s8_v_r;
      s10_v_r <= s9_v_r;
      s11_v_r <= s10_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s6_u_r    <= u_nxt;
    s6_sat_r  <= usat_nxt;
    s6_last_r <= d1_sb.last;

    s7_mp_r   <= pm_nxt[WORD_W-1:0];
    s7_mq_r   <= qm_nxt[WORD_W-1:0];
    s7_sb_r   <= '{u: s6_u_r, sat_u: s6_sat_r, pz: (p_nxt == '0) || (q_nxt == '0),
                   ovf: 1'b0, last: s6_last_r};

    s8_pp_r   <= PP_W'(s7_mp_r) * PP_W'(s7_mp_r);
    s8_qq_r   <= PP_W'(s7_mq_r) * PP_W'(s7_mq_r);
    s8_sb_r   <= s7_sb_r;

    s9_ll_r   <= PP_W'(s8_pp_r[WORD_W-1:0]) * PP_W'(s8_qq_r[WORD_W-1:0]);
    s9_lh_r   <= PP_W'(s8_pp_r[WORD_W-1:0]) * PP_W'(s8_qq_r[PP_W-1:WORD_W]);
    s9_hl_r   <= PP_W'(s8_pp_r[PP_W-1:WORD_W]) * PP_W'(s8_qq_r[WORD_W-1:0]);
    s9_hh_r   <= PP_W'(s8_pp_r[PP_W-1:WORD_W]) * PP_W'(s8_qq_r[PP_W-1:WORD_W]);
    s9_pq_r   <= {1'b0, s8_pp_r} + {1'b0, s8_qq_r};
    s9_sb_r   <= s8_sb_r;

    s10_n_r   <= n2_nxt;
    s10_den_r <= {s9_pq_r, {FRAC_W{1'b0}}};
    s10_sb_r  <= s9_sb_r;

    s11_n_r   <= s10_n_r;
    s11_den_r <= s10_den_r;
    s11_sb_r  <= '{u: s10_sb_r.u, sat_u: s10_sb_r.sat_u, pz: s10_sb_r.pz,
                   ovf: ovf_nxt, last: s10_sb_r.last};
  end

  // ---------------- du = p^2 q^2 / ((p^2 + q^2) 2^F) ----------------
  logic            d2_v;
  logic [DU_W-1:0] d2_q;
  div2_sb_t        d2_sb;

  lbce_div_pipe #(
    .NUM_W (NUM2_W),
    .DEN_W (DEN2_W),
    .Q_W   (DU_W),
    .SB_W  ($bits(div2_sb_t))
  ) u_div_du (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (s11_v_r),
    .in_num  (s11_n_r),
    .in_den  (s11_den_r),
    .in_sb   (s11_sb_r),
    .out_v   (d2_v),
    .out_quo (d2_q),
    .out_sb  (d2_sb)
  );

  logic            out_valid_r;
  logic [WORD_W-1:0] out_u_r;
  logic [DU_W-1:0] out_du_r;
  logic            out_last_r, out_sat_r;
  logic [DU_W-1:0] du_nxt;

  always_comb begin
    if (d2_sb.pz) begin
      du_nxt = '0;
    end else if (d2_sb.ovf) begin
      du_nxt = DU_MAX;
    end else begin
      du_nxt = d2_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    out_u_r    <= d2_sb.u;
    out_du_r   <= du_nxt;
    out_last_r <= d2_sb.last;
    out_sat_r  <= d2_sb.sat_u || (!d2_sb.pz && d2_sb.ovf);
  end

  assign out_valid     = out_valid_r;
  assign out_u_value   = out_u_r;
  assign out_du_value  = out_du_r;
  assign out_last_out  = out_last_r;
  assign out_saturated = out_sat_r;

  // ---------------- checks ----------------
  a_word_emerges: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted word did not emerge");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without matching start");

  a_bound_du_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_u_value == lower_r || out_u_value == upper_r)) |->
      out_du_value == '0)
    else $error("derivative nonzero on a bound");

  a_equal_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && lower_r == upper_r) |->
      (out_u_value == lower_r && out_du_value == '0))
    else $error("equal bounds gave wrong result");

endmodule

[hdl/lbce_sqrt_pipe.sv]
`timescale 1ns / 1ps
module lbce_sqrt_pipe #(
  parameter int ROOT_W = 64,
  parameter int SB_W   = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_v,
  input  logic [2*ROOT_W-1:0]   in_n,
  input  logic [SB_W-1:0]       in_sb,
  output logic                  out_v,
  output logic [ROOT_W-1:0]     out_root,
  output logic [SB_W-1:0]       out_sb
);

  localparam int N_W   = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 1;

  logic [ROOT_W:1]   v_r;
  logic [N_W-1:0]    n_r    [1:ROOT_W-1];
  logic [REM_W-1:0]  rem_r  [1:ROOT_W-1];
  logic [ROOT_W-1:0] root_r [1:ROOT_W];
  logic [SB_W-1:0]   sb_r   [1:ROOT_W];

  // stage inputs: the ports for stage 0, the stage registers after that
  logic [ROOT_W-1:0] v_w;
  logic [N_W-1:0]    n_w    [0:ROOT_W-1];
  logic [REM_W-1:0]  rem_w  [0:ROOT_W-1];
  logic [ROOT_W-1:0] root_w [0:ROOT_W-1];
  logic [SB_W-1:0]   sb_w   [0:ROOT_W-1];

  logic [REM_W+1:0]  pre_w   [0:ROOT_W-1];
  logic [REM_W+1:0]  trial_w [0:ROOT_W-1];
  logic              ge_w    [0:ROOT_W-1];

  always_comb begin
    v_w       = {v_r[ROOT_W-1:1], in_v};
    n_w[0]    = in_n;
    rem_w[0]  = '0;
    root_w[0] = '0;
    sb_w[0]   = in_sb;
    for (int k = 1; k < ROOT_W; k++) begin
      n_w[k]    = n_r[k];
      rem_w[k]  = rem_r[k];
      root_w[k] = root_r[k];
      sb_w[k]   = sb_r[k];
    end
  end

  // one root bit per stage, two radicand bits consumed from the top
  always_comb begin
    for (int k = 0; k < ROOT_W; k++) begin
      pre_w[k]   = {rem_w[k], n_w[k][N_W-1 -: 2]};
      trial_w[k] = {1'b0, root_w[k], 2'b01};
      ge_w[k]    = pre_w[k] >= trial_w[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_w;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ROOT_W; k++) begin
      root_r[k+1] <= {root_w[k][ROOT_W-2:0], ge_w[k]};
      sb_r[k+1]   <= sb_w[k];
    end
    for (int k = 0; k < ROOT_W - 1; k++) begin
      n_r[k+1]   <= n_w[k] << 2;
      rem_r[k+1] <= ge_w[k] ? REM_W'(pre_w[k] - trial_w[k]) : REM_W'(pre_w[k]);
    end
  end

  assign out_v    = v_r[ROOT_W];
  assign out_root = root_r[ROOT_W];
  assign out_sb   = sb_r[ROOT_W];

endmodule

[hdl/lbce_div_pipe.sv]
`timescale 1ns / 1ps
module lbce_div_pipe #(
  parameter int NUM_W = 96,
  parameter int DEN_W = 65,
  parameter int Q_W   = 32,
  parameter int SB_W  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_v,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_v,
  output logic [Q_W-1:0]    out_quo,
  output logic [SB_W-1:0]   out_sb
);

  // caller guarantees num >> Q_W < den, so the quotient fits in Q_W bits

  logic [Q_W:1]     v_r;
  logic [DEN_W-1:0] rem_r [1:Q_W-1];
  logic [Q_W-1:0]   x_r   [1:Q_W];
  logic [DEN_W-1:0] den_r [1:Q_W-1];
  logic [SB_W-1:0]  sb_r  [1:Q_W];

  logic [Q_W-1:0]   v_w;
  logic [DEN_W-1:0] rem_w [0:Q_W-1];
  logic [Q_W-1:0]   x_w   [0:Q_W-1];
  logic [DEN_W-1:0] den_w [0:Q_W-1];
  logic [SB_W-1:0]  sb_w  [0:Q_W-1];

  logic [DEN_W:0]   t_w   [0:Q_W-1];
  logic             ge_w  [0:Q_W-1];

  always_comb begin
    v_w      = {v_r[Q_W-1:1], in_v};
    rem_w[0] = DEN_W'(in_num >> Q_W);
    x_w[0]   = in_num[Q_W-1:0];
    den_w[0] = in_den;
    sb_w[0]  = in_sb;
    for (int k = 1; k < Q_W; k++) begin
      rem_w[k] = rem_r[k];
      x_w[k]   = x_r[k];
      den_w[k] = den_r[k];
      sb_w[k]  = sb_r[k];
    end
  end

  always_comb begin
    for (int k = 0; k < Q_W; k++) begin
      t_w[k]  = {rem_w[k], x_w[k][Q_W-1]};
      ge_w[k] = t_w[k] >= {1'b0, den_w[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_w;
    end
  end

  // numerator bits shift out the top of x while quotient bits shift in
  always_ff @(posedge clk) begin
    for (int k = 0; k < Q_W; k++) begin
      x_r[k+1]  <= {x_w[k][Q_W-2:0], ge_w[k]};
      sb_r[k+1] <= sb_w[k];
    end
    for (int k = 0; k < Q_W - 1; k++) begin
      rem_r[k+1] <= ge_w[k] ? DEN_W'(t_w[k] - {1'b0, den_w[k]}) : DEN_W'(t_w[k]);
      den_r[k+1] <= den_w[k];
    end
  end

  assign out_v   = v_r[Q_W];
  assign out_quo = x_r[Q_W];
  assign out_sb  = sb_r[Q_W];

endmodule
